### rtl/kef_pkg.sv
`default_nettype none

package kef_pkg;

    localparam int KEF_FIFO_DEPTH = 16;
    localparam int KEF_WORD_W     = 32;
    localparam int KEF_FILL_W     = 5;

    typedef enum logic [1:0] {
        CMD_PUSH      = 2'd0,
        CMD_OVERWRITE = 2'd1,
        CMD_POP       = 2'd2,
        CMD_PEEK      = 2'd3
    } t_kef_cmd;

    typedef struct packed {
        t_kef_cmd                command;
        logic [KEF_WORD_W-1:0]   write_value;
    } t_kef_in;

    typedef struct packed {
        logic [KEF_WORD_W-1:0]   read_value;
        logic [KEF_FILL_W-1:0]   fill_count;
        logic                    dropped_oldest;
        logic                    read_empty;
    } t_kef_out;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
    } t_kef_ctrl;

endpackage

`default_nettype wire

### rtl/kef_ctrl.sv
`default_nettype none

module kef_ctrl
    import kef_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      start,
    output logic           busy,
    output logic           o_done,
    output t_kef_ctrl      o_ctrl
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_done <= 1'b0;
                    if (start) begin
                        r_state <= S_EXEC;
                        r_busy  <= 1'b1;
                    end
                end
                S_EXEC: begin
                    r_state <= S_RESP;
                    r_done  <= 1'b1;
                end
                S_RESP: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                    r_done  <= 1'b0;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                    r_done  <= 1'b0;
                end
            endcase
        end
    end

    assign busy        = r_busy;
    assign o_done      = r_done;
    assign o_ctrl.load = start && !r_busy;
    assign o_ctrl.exec = (r_state == S_EXEC);

endmodule

`default_nettype wire

### rtl/kef_datapath.sv
`default_nettype none

module kef_datapath
    import kef_pkg::*;
#(
    parameter int FIFO_DEPTH = KEF_FIFO_DEPTH
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_kef_ctrl i_ctrl,
    input  wire t_kef_in   i_item,
    output t_kef_out       o_result
);

    localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam int SW = AW + 1;
    localparam logic [SW-1:0] DEPTH_S = SW'(FIFO_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(FIFO_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    logic [KEF_WORD_W-1:0] r_mem [FIFO_DEPTH];

    logic [AW-1:0]         r_head;
    logic [CW-1:0]         r_count;
    t_kef_cmd              r_cmd;
    logic [KEF_WORD_W-1:0] r_wval;
    logic [KEF_WORD_W-1:0] r_rd_data;
    logic                  r_hit;
    logic                  r_dropped;
    logic                  r_empty;

    logic [CW-1:0]         n_count;
    logic [AW-1:0]         n_head;
    logic [CW-1:0]         wr_off;
    logic [SW-1:0]         wr_sum;
    logic [SW-1:0]         hd_sum;
    logic [AW-1:0]         wr_idx;
    logic [AW-1:0]         hd_next;
    logic                  is_write;
    logic                  is_empty;
    logic                  is_full;
    logic                  ovw_live;

    assign is_write = (r_cmd == CMD_PUSH) || (r_cmd == CMD_OVERWRITE);
    assign is_empty = (r_count == '0);
    assign is_full  = (r_count == DEPTH_C);
    assign ovw_live = (r_cmd == CMD_OVERWRITE) && !is_empty;

    // tail slot, or the newest slot for a live overwrite; full wraps onto the head
    assign wr_off  = ovw_live ? (r_count - ONE_C) : r_count;
    assign wr_sum  = SW'(r_head) + SW'(wr_off);
    assign wr_idx  = (wr_sum >= DEPTH_S) ? AW'(wr_sum - DEPTH_S) : AW'(wr_sum);
    assign hd_sum  = SW'(r_head) + SW'(1);
    assign hd_next = (hd_sum >= DEPTH_S) ? AW'(hd_sum - DEPTH_S) : AW'(hd_sum);

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (ovw_live) begin
            n_count = r_count;
        end else if (is_write) begin
            if (is_full) begin
                n_head = hd_next;
            end else begin
                n_count = r_count + ONE_C;
            end
        end else if (!is_empty && (r_cmd == CMD_POP)) begin
            n_head  = hd_next;
            n_count = r_count - ONE_C;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_ctrl.exec) begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd  <= i_item.command;
            r_wval <= i_item.write_value;
        end
        if (i_ctrl.exec) begin
            r_hit     <= !is_write && !is_empty;
            r_dropped <= is_write && !ovw_live && is_full;
            r_empty   <= !is_write && is_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.exec && is_write) begin
            r_mem[wr_idx] <= r_wval;
        end
        if (i_ctrl.exec) begin
            r_rd_data <= r_mem[r_head];
        end
    end

    assign o_result.read_value     = r_hit ? r_rd_data : '0;
    assign o_result.fill_count     = KEF_FILL_W'(r_count);
    assign o_result.dropped_oldest = r_dropped;
    assign o_result.read_empty     = r_empty;

endmodule

`default_nettype wire

### rtl/key_event_fifo_drop_oldest.sv
// Drop-oldest FIFO of 32-bit key event words.
// Input channel: present a word on i_item with start high; it is taken at the
// rising edge where start is high and busy is low. Commands: push, overwrite
// newest, pop oldest, peek oldest.
// Result channel: o_result is valid for exactly one cycle while o_done is high
// and is taken at the edge that ends that cycle. There is no back-pressure:
// the receiver must capture every word as it appears.
// Sequence: the accepting edge moves the controller to execute, where the
// pointers are updated, the head slot is read and the target slot written;
// o_done then rises for the response cycle, whose end takes the result word.
// A new word is taken only once the controller's idle/execute/respond sequence
// has run; busy stays high until the response cycle ends.
// Push on a full FIFO discards the oldest word and flags dropped_oldest.
// Reads of an empty FIFO return zero with read_empty set; state is kept.
// Reset (synchronous, active low) empties the FIFO and returns the controller
// to idle; the entry store itself is not cleared, since only written words
// are ever read back.
`default_nettype none

module key_event_fifo_drop_oldest
    import kef_pkg::*;
#(
    parameter int FIFO_DEPTH = KEF_FIFO_DEPTH
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    start,
    input  wire t_kef_in i_item,
    output logic         busy,
    output logic         o_done,
    output t_kef_out     o_result
);

    t_kef_ctrl ctrl;

    // sequence each word: accept, execute, respond
    kef_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .o_ctrl  (ctrl)
    );

    // hold head, count and the circular entry store
    kef_datapath #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (ctrl),
        .i_item   (i_item),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

### rtl/kef_checker.sv
`default_nettype none

module kef_port_checks
    import kef_pkg::*;
(
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     start,
    input wire t_kef_in  i_item,
    input wire logic     busy,
    input wire logic     o_done,
    input wire t_kef_out o_result
);

    logic accept;
    assign accept = start && !busy;

    a_resp_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##2 o_done)
        else $error("result word missing two cycles after accept");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("busy low after accepting a word");

    a_empty_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.read_empty) |->
            (o_result.read_value == '0 && o_result.fill_count == '0
             && !o_result.dropped_oldest))
        else $error("empty read carries data or a drop");

endmodule

bind key_event_fifo_drop_oldest kef_port_checks u_kef_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .i_item   (i_item),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);

`default_nettype wire

### tb/sv/kef_checker.sv
`default_nettype none

module kef_checker
    import kef_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire logic     i_busy,
    input  wire t_kef_in  i_item,
    input  wire logic     i_done,
    input  wire t_kef_out i_result,
    output int            o_fail_count,
    output int            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOT_W = $clog2(KEF_FIFO_DEPTH);

    // mirror of the block's storage
    logic [KEF_WORD_W-1:0] key_words [KEF_FIFO_DEPTH];
    logic [SLOT_W-1:0]     oldest_slot;
    logic [KEF_FILL_W-1:0] word_total;

    t_kef_out awaited_words[$];

    function automatic logic [SLOT_W-1:0] slot_from(input int offset);
        return SLOT_W'((int'(oldest_slot) + offset) % KEF_FIFO_DEPTH);
    endfunction

    // advance the mirror by one command word and return the result it should give
    task automatic apply_command(input t_kef_in word_in, output t_kef_out word_out);
        word_out = '0;
        if (word_in.command == CMD_OVERWRITE && word_total != 0) begin
            key_words[slot_from(int'(word_total) - 1)] = word_in.write_value;
        end else if (word_in.command == CMD_PUSH || word_in.command == CMD_OVERWRITE) begin
            if (word_total == KEF_FILL_W'(KEF_FIFO_DEPTH)) begin
                oldest_slot = slot_from(1);
                word_total  = word_total - 1'b1;
                word_out.dropped_oldest = 1'b1;
            end
            key_words[slot_from(int'(word_total))] = word_in.write_value;
            word_total = word_total + 1'b1;
        end else if (word_total == 0) begin
            word_out.read_empty = 1'b1;
        end else begin
            word_out.read_value = key_words[slot_from(0)];
            if (word_in.command == CMD_POP) begin
                oldest_slot = slot_from(1);
                word_total  = word_total - 1'b1;
            end
        end
        word_out.fill_count = word_total;
    endtask

    task automatic report_field(input string field, input longint want, input longint got);
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_kef_out predicted;
        t_kef_out oldest;
        if (!i_rst_n) begin
            oldest_slot  = '0;
            word_total   = '0;
            o_fail_count = 0;
            awaited_words.delete();
        end else begin
            if (i_done) begin
                if (awaited_words.size() == 0) begin
                    $display("%0t: unexpected result word, actual 0x%0h", $time, i_result);
                    o_fail_count++;
                end else begin
                    oldest = awaited_words.pop_front();
                    if (i_result.read_value !== oldest.read_value)
                        report_field("read_value", oldest.read_value, i_result.read_value);
                    if (i_result.fill_count !== oldest.fill_count)
                        report_field("fill_count", oldest.fill_count, i_result.fill_count);
                    if (i_result.dropped_oldest !== oldest.dropped_oldest)
                        report_field("dropped_oldest", oldest.dropped_oldest,
                                     i_result.dropped_oldest);
                    if (i_result.read_empty !== oldest.read_empty)
                        report_field("read_empty", oldest.read_empty, i_result.read_empty);
                end
            end
            if (i_start && !i_busy) begin
                apply_command(i_item, predicted);
                awaited_words.push_back(predicted);
            end
        end
        o_pending = awaited_words.size();
    end

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import kef_pkg::*;

    // cycles with neither a word taken nor a result seen before giving up
    localparam int WATCHDOG_LIMIT = 2000;
    // wait after the last result is seen, as slack before the run ends
    localparam int DRAIN_CYCLES   = 10;
    localparam int RANDOM_WORDS   = 800;
    // the last stretch of the run is sent back to back
    localparam int CALM_TAIL      = 100;
    localparam int SEGMENT_WORDS  = 40;

    localparam logic [KEF_WORD_W-1:0] ALL_ONES = '1;

    // stream biases for the random part
    typedef enum int {
        BIAS_FILL,
        BIAS_DRAIN,
        BIAS_MIXED
    } t_stream_bias;

    logic     clk;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    t_kef_in  item  = '0;
    wire      busy;
    wire      done;
    t_kef_out result;

    int fail_count;
    int pending;
    int idle_odds;
    int stall_cycles;

    key_event_fifo_drop_oldest u_top (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .start    (start),
        .i_item   (item),
        .busy     (busy),
        .o_done   (done),
        .o_result (result)
    );

    kef_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (item),
        .i_done       (done),
        .i_result     (result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one command word and hold it until the block takes it. A random
    // idle burst may come first; start is lowered once and raised once, never
    // both in the same step.
    task automatic send_word(input t_kef_cmd cmd, input logic [KEF_WORD_W-1:0] value);
        if (idle_odds != 0 && $urandom_range(0, 99) < idle_odds) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        start <= 1'b1;
        item  <= '{command: cmd, write_value: value};
        @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    // Favour the extremes now and then so that empty and full words turn up often.
    function automatic logic [KEF_WORD_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return ALL_ONES;
            default: return KEF_WORD_W'($urandom);
        endcase
    endfunction

    // Fill-biased streams reach the full state and the drop; drain-biased ones
    // empty the FIFO and hit reads on empty.
    function automatic t_kef_cmd pick_command(input t_stream_bias bias);
        int roll;
        roll = $urandom_range(0, 99);
        case (bias)
            BIAS_FILL: begin
                if (roll < 60) return CMD_PUSH;
                if (roll < 75) return CMD_OVERWRITE;
                if (roll < 90) return CMD_POP;
                return CMD_PEEK;
            end
            BIAS_DRAIN: begin
                if (roll < 20) return CMD_PUSH;
                if (roll < 30) return CMD_OVERWRITE;
                if (roll < 80) return CMD_POP;
                return CMD_PEEK;
            end
            default: begin
                if (roll < 35) return CMD_PUSH;
                if (roll < 50) return CMD_OVERWRITE;
                if (roll < 80) return CMD_POP;
                return CMD_PEEK;
            end
        endcase
    endfunction

    // Watchdog: count cycles in which nothing moves on either channel.
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || done) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired with %0d results outstanding", $time, pending);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        t_stream_bias bias;
        idle_odds = 0;

        // hold reset at the start, then release it once for good
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: reads on empty, overwrite on empty acting as a push,
        // overwrite of the newest word, fill to the brim, overwrite on full
        // (nothing dropped), push on full (oldest dropped), then read back.
        send_word(CMD_POP, ALL_ONES);
        send_word(CMD_PEEK, ALL_ONES);
        send_word(CMD_OVERWRITE, ALL_ONES);
        send_word(CMD_PEEK, '0);
        send_word(CMD_OVERWRITE, '0);
        send_word(CMD_POP, '0);
        send_word(CMD_PUSH, ALL_ONES);
        for (int k = 1; k < KEF_FIFO_DEPTH; k++) begin
            send_word(CMD_PUSH, KEF_WORD_W'(32'h0101_0101 * k));
        end
        send_word(CMD_OVERWRITE, 32'h5A5A_5A5A);
        send_word(CMD_PUSH, 32'hA5A5_A5A5);
        send_word(CMD_PEEK, '0);
        send_word(CMD_POP, '0);

        // Random part: segments with their own command bias and idle rate,
        // some of them with no idling at all; the tail runs flat out.
        bias = BIAS_MIXED;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % SEGMENT_WORDS == 0) begin
                bias = t_stream_bias'($urandom_range(0, 2));
                case ($urandom_range(0, 3))
                    0: idle_odds = 0;
                    1: idle_odds = 10;
                    2: idle_odds = 30;
                    default: idle_odds = 60;
                endcase
            end
            if (n >= RANDOM_WORDS - CALM_TAIL) idle_odds = 0;
            send_word(pick_command(bias), pick_value());
        end
        start <= 1'b0;

        // let the checker see the last accept, then wait out the results
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
rtl/kef_pkg.sv
rtl/kef_ctrl.sv
rtl/kef_datapath.sv
rtl/key_event_fifo_drop_oldest.sv
rtl/kef_checker.sv
tb/sv/kef_checker.sv
tb/sv/tb_top.sv
